// ----- src/bsws_pkg.sv -----
// Shared types and codes for the bounded stack with statistics.
// No dependencies; imported by bounded_stack_with_stats.
package bsws_pkg;

    localparam int DEPTH_DEF = 64;

    // request codes
    localparam logic [2:0] REQ_PUSH     = 3'd0;
    localparam logic [2:0] REQ_POP      = 3'd1;
    localparam logic [2:0] REQ_POP_RET  = 3'd2;
    localparam logic [2:0] REQ_STATS    = 3'd3;
    localparam logic [2:0] REQ_REVERSE  = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] push_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] popped_value;
        logic signed [31:0] largest;
        logic signed [31:0] smallest;
        logic signed [39:0] mean_value;
        logic [6:0]         entry_count;
    } rsp_t;

endpackage

// ----- src/bounded_stack_with_stats.sv -----
// Bounded LIFO stack of signed words held in one single-port-read, single-port-write RAM.
// Push and pop-discard finish straight from idle; pop-return passes through ST_POP;
// reverse steps ST_RV_RA, ST_RV_RB, ST_RV_WA, ST_RV_WB per swapped pair; statistics
// makes one RAM read per entry, then runs a bit-serial divider. One transaction in
// flight; busy is high outside idle. Results are never held off. Reset clears count and
// control state; RAM is not swept. Depends on bsws_pkg.
module bounded_stack_with_stats
    import bsws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  req_t req,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 32 + AW;            // sum never overflows
    localparam int NW = SW + 8;             // scaled magnitude / quotient
    localparam int MW = (NW + 1 > 40) ? NW + 1 : 40;
    localparam int DW = $clog2(NW);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_POP   = 9'b000000010,
        ST_STAT  = 9'b000000100,
        ST_DIV   = 9'b000001000,
        ST_FIN   = 9'b000010000,
        ST_RV_RA = 9'b000100000,
        ST_RV_RB = 9'b001000000,
        ST_RV_WA = 9'b010000000,
        ST_RV_WB = 9'b100000000
    } state_t;

    logic [31:0] stack_mem [DEPTH];
    logic [31:0] rd_data_reg;
    logic        mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   mem_wdata;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          rd_pend_reg, rd_pend_next;
    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;
    logic signed [31:0] max_reg, max_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic [NW-1:0] num_reg, num_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          neg_reg, neg_next;
    logic [DW-1:0] step_reg, step_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [31:0]   tmp_reg, tmp_next;

    logic [CW:0]   rem_sh;
    logic [SW-1:0] sum_mag;
    logic [MW-1:0] q_ext;
    logic [MW-1:0] q_sgn;
    logic [CW+6:0] cnt_ext;
    logic [CW-1:0] cnt_m1;

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // RAM: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[mem_raddr];
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        sum_next     = sum_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        tmp_next     = tmp_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        cnt_m1  = count_reg - 1'b1;
        rem_sh  = {rem_reg, num_reg[NW-1]};
        sum_mag = sum_reg[SW-1] ? (~sum_reg + 1'b1) : sum_reg;
        q_ext   = {{(MW-NW){1'b0}}, num_reg};
        q_sgn   = neg_reg ? (~q_ext + 1'b1) : q_ext;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type)
                        REQ_PUSH:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                            if (count_reg == CW'(DEPTH))
                            begin
                                rsp_next.status = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = req.push_value;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_POP, REQ_POP_RET:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next       = 1'b1;
                                rsp_next        = '0;
                                rsp_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                mem_raddr  = cnt_m1[AW-1:0];
                                if (req.req_type == REQ_POP)
                                begin
                                    done_next = 1'b1;
                                    rsp_next  = '0;
                                end
                                else
                                begin
                                    state_next = ST_POP;
                                end
                            end
                        end
                        REQ_STATS:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next       = 1'b1;
                                rsp_next        = '0;
                                rsp_next.status = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                max_next   = 32'sh8000_0000;
                                min_next   = 32'sh7fff_ffff;
                                sum_next   = '0;
                                state_next = ST_STAT;
                            end
                        end
                        REQ_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                lo_next    = '0;
                                hi_next    = cnt_m1[AW-1:0];
                                state_next = ST_RV_RA;
                            end
                            else
                            begin
                                done_next = 1'b1;
                                rsp_next  = '0;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '0;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                done_next             = 1'b1;
                rsp_next              = '0;
                rsp_next.popped_value = rd_data_reg;
                state_next            = ST_IDLE;
            end
            ST_STAT:
            begin
                if (rd_pend_reg)
                begin
                    sum_next = sum_reg + {{(SW-32){rd_data_reg[31]}}, rd_data_reg};
                    if ($signed(rd_data_reg) > max_reg)
                    begin
                        max_next = rd_data_reg;
                    end
                    if ($signed(rd_data_reg) < min_reg)
                    begin
                        min_next = rd_data_reg;
                    end
                end
                if (idx_reg < count_reg)
                begin
                    mem_raddr    = idx_reg[AW-1:0];
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    num_next   = {sum_mag, 8'b0};
                    neg_next   = sum_reg[SW-1];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, count_reg})
                begin
                    rem_next = CW'(rem_sh - {1'b0, count_reg});
                    num_next = {num_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh[CW-1:0];
                    num_next = {num_reg[NW-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == DW'(NW - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                done_next           = 1'b1;
                rsp_next            = '0;
                rsp_next.largest    = max_reg;
                rsp_next.smallest   = min_reg;
                rsp_next.mean_value = q_sgn[39:0];
                state_next          = ST_IDLE;
            end
            ST_RV_RA:
            begin
                mem_raddr  = lo_reg;
                state_next = ST_RV_RB;
            end
            ST_RV_RB:
            begin
                mem_raddr  = hi_reg;
                tmp_next   = rd_data_reg;
                state_next = ST_RV_WA;
            end
            ST_RV_WA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = rd_data_reg;
                state_next = ST_RV_WB;
            end
            ST_RV_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = tmp_reg;
                lo_next   = lo_reg + 1'b1;
                hi_next   = hi_reg - 1'b1;
                if (({1'b0, lo_reg} + 2'd2) < {1'b0, hi_reg})
                begin
                    state_next = ST_RV_RA;
                end
                else
                begin
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // count reported after the transaction, modulo 2^7
        cnt_ext = {7'b0, count_next};
        if (done_next)
        begin
            rsp_next.entry_count = cnt_ext[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            done_reg    <= done_next;
            step_reg    <= step_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        max_reg <= max_next;
        min_reg <= min_next;
        sum_reg <= sum_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        tmp_reg <= tmp_next;
    end

endmodule

// ----- bench/bounded_stack_with_stats_checker.sv -----
// Checker for the bounded stack: tracks its own copy of the stack, predicts each
// response and compares it with what the block returns on done.
// Depends on bsws_pkg.
module bounded_stack_with_stats_checker
    import bsws_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t req,
    input  logic done,
    input  rsp_t rsp,
    output int   errors,
    output int   outstanding,
    output int   checked,
    output int   empty_hits,
    output int   full_hits,
    output int   deepest
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_LIMIT = 10;

    logic signed [31:0] words [DEPTH];
    int   fill       = 0;
    int   err_cnt    = 0;
    int   chk_cnt    = 0;
    int   empty_cnt  = 0;
    int   full_cnt   = 0;
    int   peak_fill  = 0;
    rsp_t rsp_due[$];

    assign errors      = err_cnt;
    assign outstanding = rsp_due.size();
    assign checked     = chk_cnt;
    assign empty_hits  = empty_cnt;
    assign full_hits   = full_cnt;
    assign deepest     = peak_fill;

    // Applies one request to the local stack and returns the response it earns.
    function automatic rsp_t stack_apply(req_t r);
        rsp_t               o;
        longint             acc;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic signed [31:0] t;
        int                 a;
        int                 b;
        o = '0;
        case (r.req_type)
            REQ_PUSH:
                if (fill >= DEPTH)
                    o.status = STAT_FULL;
                else
                begin
                    words[fill] = r.push_value;
                    fill++;
                end
            REQ_POP, REQ_POP_RET:
                if (fill == 0)
                    o.status = STAT_EMPTY;
                else
                begin
                    fill--;
                    if (r.req_type == REQ_POP_RET)
                        o.popped_value = words[fill];
                end
            REQ_STATS:
                if (fill == 0)
                    o.status = STAT_EMPTY;
                else
                begin
                    hi  = words[0];
                    lo  = words[0];
                    acc = 0;
                    for (int i = 0; i < fill; i++)
                    begin
                        acc += longint'(words[i]);
                        if (words[i] > hi)
                            hi = words[i];
                        if (words[i] < lo)
                            lo = words[i];
                    end
                    o.largest    = hi;
                    o.smallest   = lo;
                    // longint division truncates toward zero
                    o.mean_value = 40'((acc * 256) / longint'(fill));
                end
            REQ_REVERSE:
            begin
                a = 0;
                b = fill - 1;
                while (a < b)
                begin
                    t        = words[a];
                    words[a] = words[b];
                    words[b] = t;
                    a++;
                    b--;
                end
            end
            default: ;
        endcase
        o.entry_count = 7'(fill);
        return o;
    endfunction

    function automatic string rsp_text(rsp_t r);
        return $sformatf("st=%0d pop=%0d hi=%0d lo=%0d mean=%0d cnt=%0d",
                         r.status, r.popped_value, r.largest, r.smallest,
                         r.mean_value, r.entry_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            fill = 0;
            rsp_due.delete();
        end
        else
        begin
            // results first: a response and the next request can share an edge
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= SHOW_LIMIT)
                        $display("%t: response with no transaction pending: %s",
                                 $realtime, rsp_text(rsp));
                end
                else
                begin
                    want = rsp_due.pop_front();
                    chk_cnt++;
                    if (rsp.status !== want.status ||
                        rsp.popped_value !== want.popped_value ||
                        rsp.largest !== want.largest ||
                        rsp.smallest !== want.smallest ||
                        rsp.mean_value !== want.mean_value ||
                        rsp.entry_count !== want.entry_count)
                    begin
                        err_cnt++;
                        if (err_cnt <= SHOW_LIMIT)
                        begin
                            $display("%t: mismatch, expected %s", $realtime, rsp_text(want));
                            $display("%t:             actual %s", $realtime, rsp_text(rsp));
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                want = stack_apply(req);
                if (want.status == STAT_EMPTY)
                    empty_cnt++;
                if (want.status == STAT_FULL)
                    full_cnt++;
                if (fill > peak_fill)
                    peak_fill = fill;
                rsp_due.push_back(want);
            end
        end
    end

endmodule

// ----- bench/bounded_stack_with_stats_tb.sv -----
// Top of the stack testbench: clock, reset, request stimulus and the verdict.
// Depends on bsws_pkg, bounded_stack_with_stats and bounded_stack_with_stats_checker.
module bounded_stack_with_stats_tb
    import bsws_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         STALL_LIMIT      = 4000;
    localparam int         DRAIN_CYCLES     = 150;
    localparam int         PHASES           = 8;
    localparam int         PHASE_ITEMS      = 144;
    localparam logic [2:0] REQ_UNUSED_FIRST = REQ_REVERSE + 3'd1;
    localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

    typedef enum int { LEAN_FILL, LEAN_EVEN, LEAN_DRAIN } lean_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    int errors;
    int outstanding;
    int checked;
    int empty_hits;
    int full_hits;
    int deepest;
    int idle_pct     = 0;
    int quiet_cycles = 0;

    bounded_stack_with_stats dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    bounded_stack_with_stats_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked),
        .empty_hits  (empty_hits),
        .full_hits   (full_hits),
        .deepest     (deepest)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Holds start until the block takes the request; may idle first.
    task automatic send_req(input logic [2:0] kind, input logic signed [31:0] word);
        req_t r;
        r.req_type   = kind;
        r.push_value = word;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'($urandom_range(0, 15));
            3:       return -32'sd1 - 32'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_kind(lean_t lean);
        int roll;
        int push_cut;
        int pop_cut;
        roll = $urandom_range(0, 99);
        case (lean)
            LEAN_FILL:  begin push_cut = 75; pop_cut = 85; end
            LEAN_DRAIN: begin push_cut = 20; pop_cut = 70; end
            default:    begin push_cut = 40; pop_cut = 70; end
        endcase
        if (roll < push_cut)
            return REQ_PUSH;
        if (roll < pop_cut)
            return $urandom_range(0, 1) ? REQ_POP : REQ_POP_RET;
        if (roll < pop_cut + (100 - pop_cut) / 2)
            return REQ_STATS;
        if (roll < 96)
            return REQ_REVERSE;
        return 3'($urandom_range(32'(REQ_UNUSED_FIRST), 32'(REQ_UNUSED_LAST)));
    endfunction

    initial
    begin
        lean_t lean;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stack, single entry, extremes, and a negative mean that truncates
        send_req(REQ_STATS, 32'sd0);
        send_req(REQ_POP, 32'sd0);
        send_req(REQ_POP_RET, 32'sd0);
        send_req(REQ_REVERSE, 32'sd0);
        send_req(REQ_PUSH, 32'sh7fff_ffff);
        send_req(REQ_REVERSE, 32'sd0);
        send_req(REQ_STATS, 32'sd0);
        send_req(REQ_PUSH, 32'sh8000_0000);
        send_req(REQ_PUSH, -32'sd1);
        send_req(REQ_STATS, 32'sd0);
        send_req(REQ_REVERSE, 32'sd0);
        send_req(REQ_POP_RET, 32'sd0);
        send_req(REQ_POP_RET, 32'sd0);
        send_req(REQ_POP_RET, 32'sd0);
        send_req(REQ_POP_RET, 32'sd0);
        for (int k = int'(REQ_UNUSED_FIRST); k <= int'(REQ_UNUSED_LAST); k++)
            send_req(3'(k), $urandom());
        send_req(REQ_PUSH, -32'sd1);
        send_req(REQ_PUSH, 32'sd0);
        send_req(REQ_PUSH, 32'sd0);
        send_req(REQ_STATS, 32'sd0);
        send_req(REQ_POP, 32'sd0);

        // random phases: fill up to full, mix, drain to empty, under varied idling
        for (int p = 0; p < PHASES; p++)
        begin
            case (p % 3)
                0:       lean = LEAN_FILL;
                1:       lean = LEAN_EVEN;
                default: lean = LEAN_DRAIN;
            endcase
            case (p % 4)
                1:       idle_pct = 63;
                3:       idle_pct = 8;
                default: idle_pct = 0;
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_req(pick_kind(lean), pick_word());
        end
        start <= 1'b0;

        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("covered %0d checked responses, %0d empty and %0d full statuses",
                 checked, empty_hits, full_hits);
        $display("deepest stack reached %0d entries", deepest);
        if (errors == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
